/* design/hns_pkg.sv */
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants for the height map normal stream block.
// ----------------------------------------------------------------------------
package hns_pkg;

    // line buffer geometry
    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = 10;
    localparam int MAX_ROWS = 1024;

    // configuration and payload widths
    localparam int CNT_W  = 11;
    localparam int H_W    = 16;
    localparam int D_W    = H_W + 1;
    localparam int SQ_W   = 2 * D_W;
    localparam int Q_W    = 15;
    localparam int N_W    = 16;
    localparam int ACC_W  = 70;

    // magnitude search: one result bit per step, MSB first
    localparam int STEP_COUNT = Q_W;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam int F_SHIFT    = STEP_COUNT + 1;
    localparam int S_SHIFT    = 2 * STEP_COUNT;
    localparam int T_SHIFT    = 30;

    // the height axis component is 1.0 in Q8.8
    localparam int UNIT_H   = 256;
    localparam int UNIT_SQR = UNIT_H * UNIT_H;

    // configuration register index (byte address bit 2)
    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } reg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic diff;
        logic square;
        logic init;
        logic step;
        logic load_out;
    } hns_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic out_full;
    } hns_status_t;

endpackage

/* design/hns_lane.sv */
// ----------------------------------------------------------------------------
// hns_lane
// Bit-serial search for round(16384 * mag / sqrt(S)). Tracks
// D = (2q-1)^2 * S with pre-shifted increments, so each step is one
// wide add and compare and no multiplier.
// ----------------------------------------------------------------------------
module hns_lane
    import hns_pkg::*;
(
    input  logic                    clk,
    input  logic                    init,
    input  logic                    step,
    input  logic [SQ_W:0]           s_val,
    input  logic [SQ_W-1:0]         mag_sq,
    output logic [Q_W-1:0]          q
);

    logic signed [ACC_W-1:0] d_reg;
    logic signed [ACC_W-1:0] fs_reg;
    logic signed [ACC_W-1:0] ss_reg;
    logic signed [ACC_W-1:0] target_reg;
    logic [Q_W-1:0]          q_reg;
    logic signed [ACC_W-1:0] s_ext;
    logic signed [ACC_W-1:0] cand;
    logic                    take;

    assign s_ext = ACC_W'(s_val);
    assign cand  = d_reg + fs_reg + ss_reg;
    assign take  = (cand <= target_reg);

    // start at q = 0 (t = -1): D = S, F = -S
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            d_reg      <= s_ext;
            fs_reg     <= -(s_ext <<< F_SHIFT);
            ss_reg     <= s_ext <<< S_SHIFT;
            target_reg <= ACC_W'(mag_sq) <<< T_SHIFT;
            q_reg      <= '0;
        end
        else if (step)
        begin
            if (take)
            begin
                d_reg  <= cand;
                fs_reg <= (fs_reg + (ss_reg <<< 1)) >>> 1;
            end
            else
            begin
                fs_reg <= fs_reg >>> 1;
            end
            ss_reg <= ss_reg >>> 2;
            q_reg  <= {q_reg[Q_W-2:0], take};
        end
    end

    assign q = q_reg;

endmodule

/* design/hns_datapath.sv */
// ----------------------------------------------------------------------------
// hns_datapath
// Line buffer, raster position, differences, squares, three magnitude
// lanes and the output register.
// ----------------------------------------------------------------------------
module hns_datapath
    import hns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  hns_cmd_t                cmd,
    output hns_status_t             status,
    input  logic [COL_W-1:0]        cols_m1,
    input  logic [ROW_W-1:0]        rows_m1,
    input  logic signed [H_W-1:0]   height_sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [N_W-1:0]   normal_x,
    output logic [Q_W-1:0]          normal_y,
    output logic signed [N_W-1:0]   normal_z,
    output logic [ROW_W-1:0]        cell_row,
    output logic [COL_W-1:0]        cell_col,
    output logic                    frame_last
);

    logic [H_W-1:0]          line_mem [MAX_COLS];
    logic [H_W-1:0]          upper_reg;

    logic [COL_W-1:0]        col_pos_reg;
    logic [ROW_W-1:0]        row_pos_reg;
    logic signed [H_W-1:0]   prev_sample_reg;
    logic signed [H_W-1:0]   prev_upper_reg;

    logic signed [H_W-1:0]   h00_reg;
    logic signed [H_W-1:0]   h10_reg;
    logic                    emit_reg;
    logic                    last_reg;
    logic [ROW_W-1:0]        crow_reg;
    logic [COL_W-1:0]        ccol_reg;

    logic signed [D_W-1:0]   dr_reg;
    logic signed [D_W-1:0]   dc_reg;
    logic [SQ_W-1:0]         dr2_reg;
    logic [SQ_W-1:0]         dc2_reg;
    logic [SQ_W:0]           s_sum;

    logic [Q_W-1:0]          qx;
    logic [Q_W-1:0]          qy;
    logic [Q_W-1:0]          qz;

    logic                    out_valid_reg;
    logic signed [N_W-1:0]   nx_reg;
    logic [Q_W-1:0]          ny_reg;
    logic signed [N_W-1:0]   nz_reg;
    logic [ROW_W-1:0]        orow_reg;
    logic [COL_W-1:0]        ocol_reg;
    logic                    olast_reg;

    logic                    col_end;
    logic                    row_end;

    assign col_end = (col_pos_reg >= cols_m1);
    assign row_end = (row_pos_reg >= rows_m1);

    // line buffer: read old entry, write new sample
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            upper_reg            <= line_mem[col_pos_reg];
            line_mem[col_pos_reg] <= height_sample;
        end
    end

    // raster position and neighbor history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            prev_sample_reg <= '0;
            prev_upper_reg  <= '0;
            emit_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                prev_sample_reg <= height_sample;
                emit_reg        <= (row_pos_reg != '0) && (col_pos_reg != '0);
                if (col_end)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= row_end ? '0 : row_pos_reg + 1'b1;
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + 1'b1;
                end
            end
            if (cmd.diff)
            begin
                prev_upper_reg <= upper_reg;
            end
        end
    end

    // per-cell operands
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            h00_reg  <= prev_upper_reg;
            h10_reg  <= prev_sample_reg;
            crow_reg <= row_pos_reg - 1'b1;
            ccol_reg <= col_pos_reg - 1'b1;
            last_reg <= row_end && col_end;
        end
        if (cmd.diff)
        begin
            dr_reg <= D_W'(h10_reg) - D_W'(h00_reg);
            dc_reg <= D_W'($signed(upper_reg)) - D_W'(h00_reg);
        end
        if (cmd.square)
        begin
            dr2_reg <= SQ_W'(dr_reg * dr_reg);
            dc2_reg <= SQ_W'(dc_reg * dc_reg);
        end
    end

    assign s_sum = (SQ_W+1)'(dr2_reg) + (SQ_W+1)'(dc2_reg) + (SQ_W+1)'(UNIT_SQR);

    hns_lane u_lane_x (
        .clk    (clk),
        .init   (cmd.init),
        .step   (cmd.step),
        .s_val  (s_sum),
        .mag_sq (dr2_reg),
        .q      (qx)
    );

    hns_lane u_lane_y (
        .clk    (clk),
        .init   (cmd.init),
        .step   (cmd.step),
        .s_val  (s_sum),
        .mag_sq (SQ_W'(UNIT_SQR)),
        .q      (qy)
    );

    hns_lane u_lane_z (
        .clk    (clk),
        .init   (cmd.init),
        .step   (cmd.step),
        .s_val  (s_sum),
        .mag_sq (dc2_reg),
        .q      (qz)
    );

    // output register; sign is opposite to the difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            nx_reg    <= (dr_reg > 0) ? -N_W'(qx) : N_W'(qx);
            ny_reg    <= qy;
            nz_reg    <= (dc_reg > 0) ? -N_W'(qz) : N_W'(qz);
            orow_reg  <= crow_reg;
            ocol_reg  <= ccol_reg;
            olast_reg <= last_reg;
        end
    end

    assign status.emit     = emit_reg;
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign cell_row   = orow_reg;
    assign cell_col   = ocol_reg;
    assign frame_last = olast_reg;

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // the height component of a unit normal is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ny_reg != '0))
        else $error("zero height component");

    // components stay within one in Q1.14
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (nx_reg <= 16384 && nx_reg >= -16384
                           && nz_reg <= 16384 && nz_reg >= -16384))
        else $error("component out of range");

endmodule

/* design/hns_ctrl.sv */
// ----------------------------------------------------------------------------
// hns_ctrl
// Sequencer: capture and difference, then, for a sample that completes a cell,
// square, lane setup, magnitude steps and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module hns_ctrl
    import hns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hns_status_t status,
    output hns_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_INIT,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_cnt_reg;
    logic [STEP_W-1:0] step_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = status.emit ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init      = 1'b1;
                step_cnt_next = STEP_W'(STEP_COUNT - 1);
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // an accepted sample always starts with the difference cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DIFF))
        else $error("capture not followed by difference");

    // lanes step only after setup or another step
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ($past(state_reg) == ST_INIT || $past(state_reg) == ST_STEP))
        else $error("step without setup");

    // no sample is taken while a cell is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> !in_ready)
        else $error("input taken during search");

endmodule

/* design/heightmap_normal_stream.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_stream
// Streaming face normals of a Q8.8 height map with one line buffer.
// ----------------------------------------------------------------------------
// Heights enter in raster order, one transfer per sample. A sample that
// completes a cell (row and column both nonzero) occupies the block through
// capture, difference, square, lane setup, 15 steps of the bit-serial
// magnitude search (one bit of all three components per cycle) and the
// output load. Other samples pass through capture and difference only.
// The next sample is taken once the search has finished and the result
// sits in the output register; it stalls only while an earlier result is
// still not taken.
// The line buffer is a 1024 x 16 memory and is not cleared after reset.
// Registers: row_count at address 0, col_count at address 4.
// ----------------------------------------------------------------------------
module heightmap_normal_stream
    import hns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [H_W-1:0]   height_sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [N_W-1:0]   normal_x,
    output logic [Q_W-1:0]          normal_y,
    output logic signed [N_W-1:0]   normal_z,
    output logic [ROW_W-1:0]        cell_row,
    output logic [COL_W-1:0]        cell_col,
    output logic                    frame_last
);

    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_count_reg;
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;
    reg_idx_t         reg_idx;
    logic             wr_en;
    hns_cmd_t         cmd;
    hns_status_t      status;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(10);
            col_count_reg <= CNT_W'(10);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROW_COUNT: row_count_reg <= pwdata[CNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[CNT_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROW_COUNT: prdata = 32'(row_count_reg);
            REG_COL_COUNT: prdata = 32'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    // clamp counts to the supported range
    always_comb
    begin
        if (row_count_reg < CNT_W'(2))
            rows_eff = CNT_W'(2);
        else if (row_count_reg > CNT_W'(MAX_ROWS))
            rows_eff = CNT_W'(MAX_ROWS);
        else
            rows_eff = row_count_reg;

        if (col_count_reg < CNT_W'(2))
            cols_eff = CNT_W'(2);
        else if (col_count_reg > CNT_W'(MAX_COLS))
            cols_eff = CNT_W'(MAX_COLS);
        else
            cols_eff = col_count_reg;
    end

    assign rows_m1 = ROW_W'(rows_eff - 1'b1);
    assign cols_m1 = COL_W'(cols_eff - 1'b1);

    hns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hns_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cols_m1       (cols_m1),
        .rows_m1       (rows_m1),
        .height_sample (height_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .frame_last    (frame_last)
    );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heightmap_normal_stream: a built-in predictor
// computes the expected normal of every completed cell, and each output
// transfer is compared field by field with the oldest expected normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import hns_pkg::*;

    typedef struct packed {
        logic signed [N_W-1:0] nx;
        logic [Q_W-1:0]        ny;
        logic signed [N_W-1:0] nz;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic                  last;
    } normal_t;

    localparam int LATENCY = 30;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [H_W-1:0] height_sample = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [N_W-1:0] normal_x;
    logic [Q_W-1:0]        normal_y;
    logic signed [N_W-1:0] normal_z;
    logic [ROW_W-1:0]      cell_row;
    logic [COL_W-1:0]      cell_col;
    logic                  frame_last;

    heightmap_normal_stream dut (.*);

    always #4 clk = ~clk;

    // predictor state
    logic [CNT_W-1:0] rows_reg = 11'd10;
    logic [CNT_W-1:0] cols_reg = 11'd10;
    logic [H_W-1:0]   line_mem [MAX_COLS];
    logic [H_W-1:0]   left_h = '0;
    logic [H_W-1:0]   upper_h = '0;
    int unsigned      row_at = 0;
    int unsigned      col_at = 0;

    normal_t     pending_normals[$];
    int          errors = 0;
    int          items_sent = 0;
    bit          idle_on = 1'b1;
    int          hold_cycles = 0;
    logic [15:0] last_h = '0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    // largest q in [0,16384] with q - 1/2 <= 16384*mag/sqrt(s)
    function automatic int unsigned unit_mag(longint unsigned mag, longint unsigned s);
        longint unsigned target;
        longint unsigned t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        target = (mag * mag) << T_SHIFT;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * longint'(mid) - 1;
            if (t * t * s <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] signed_unit(int v, longint unsigned s);
        int unsigned q;
        q = unit_mag((v < 0) ? longint'(-v) : longint'(v), s);
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    task automatic predict_normal(logic [15:0] h);
        int unsigned     nrows;
        int unsigned     ncols;
        int unsigned     c;
        int unsigned     r;
        logic [15:0]     up;
        int              dr;
        int              dc;
        longint unsigned s;
        normal_t         n;
        nrows = (rows_reg < 2) ? 2 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
        ncols = (cols_reg < 2) ? 2 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        c = col_at % MAX_COLS;
        r = row_at & 10'h3ff;
        up = line_mem[c];
        if (r >= 1 && c >= 1)
        begin
            dr = int'($signed(left_h)) - int'($signed(upper_h));
            dc = int'($signed(up)) - int'($signed(upper_h));
            s = longint'(dr) * dr + UNIT_SQR + longint'(dc) * dc;
            n.nx = signed_unit(-dr, s);
            n.ny = Q_W'(unit_mag(UNIT_H, s));
            n.nz = signed_unit(-dc, s);
            n.row = ROW_W'(r - 1);
            n.col = COL_W'(c - 1);
            n.last = (r >= nrows - 1 && c >= ncols - 1);
            pending_normals.push_back(n);
        end
        line_mem[c] = h;
        upper_h = up;
        left_h = h;
        if (c >= ncols - 1)
        begin
            col_at = 0;
            row_at = (r >= nrows - 1) ? 0 : r + 1;
        end
        else
            col_at = c + 1;
    endtask

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        normal_t e;
        if (out_valid && out_ready)
        begin
            if (pending_normals.size() == 0)
                report("unexpected transfer, cell_row", cell_row, -1);
            else
            begin
                e = pending_normals.pop_front();
                if (normal_x !== e.nx)   report("normal_x", normal_x, e.nx);
                if (normal_y !== e.ny)   report("normal_y", normal_y, e.ny);
                if (normal_z !== e.nz)   report("normal_z", normal_z, e.nz);
                if (cell_row !== e.row)  report("cell_row", cell_row, e.row);
                if (cell_col !== e.col)  report("cell_col", cell_col, e.col);
                if (frame_last !== e.last) report("frame_last", frame_last, e.last);
            end
        end
    end

    // receiver: random stalls per result, or one long hold-off on request
    initial
    begin
        int n;
        @(negedge clk);
        forever
        begin
            n = idle_on ? $urandom_range(0, 4) : 0;
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // sender and register access
    // ------------------------------------------------------------------
    task automatic send_height(logic [15:0] h);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        height_sample <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_normal(h);
        items_sent++;
        last_h = h;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_ROW_COUNT)
            rows_reg = v[CNT_W-1:0];
        else
            cols_reg = v[CNT_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b1;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CNT_W-1:0] !== v[CNT_W-1:0])
            report("register readback", prdata[CNT_W-1:0], v[CNT_W-1:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(int r, int c);
        stop_sending();
        drain();
        reg_write(REG_ROW_COUNT, r);
        reg_write(REG_COL_COUNT, c);
    endtask

    // random height: full range, extremes, or a small step from the last one
    function automatic logic [15:0] pick_height();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return last_h + 16'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    task automatic send_frame(int r, int c);
        repeat (r * c) send_height(pick_height());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values of the counts: 10 x 10 frame without any write
    task automatic test_reset_counts();
        send_frame(10, 10);
    endtask

    // extremes of the heights on a 3 x 3 frame
    task automatic test_extremes();
        logic [15:0] pat [9] = '{16'h8000, 16'h7fff, 16'h8000,
                                  16'h7fff, 16'h8000, 16'h7fff,
                                  16'h0000, 16'h0000, 16'hffff};
        set_frame(3, 3);
        foreach (pat[i]) send_height(pat[i]);
        // flat surface and a one-LSB step
        set_frame(2, 2);
        send_height(16'h0000);
        send_height(16'h0000);
        send_height(16'h0001);
        send_height(16'h0000);
    endtask

    // counts outside the legal range are clamped; an oversized column
    // count wraps at the line buffer depth, then a shrink wraps at once
    task automatic test_clamped_counts();
        set_frame(0, 1);
        send_frame(2, 2);
        set_frame(2047, 2047);
        repeat (MAX_COLS + 3) send_height(pick_height());
        set_frame(2, 2);
        send_height(pick_height());
    endtask

    // counts shrunk with the raster position mid-frame
    task automatic test_midframe_change();
        set_frame(6, 8);
        send_frame(6, 8);
        repeat (8 * 3 + 5) send_height(pick_height());
        set_frame(3, 4);
        send_frame(3, 4);
    endtask

    // long receiver hold-off fills the block, then a full drain pause
    task automatic test_backpressure();
        set_frame(6, 8);
        idle_on = 1'b0;
        hold_cycles = 300;
        send_frame(6, 8);
        stop_sending();
        while (pending_normals.size() != 0)
            @(posedge clk);
        send_frame(6, 8);
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int r;
        int c;
        while (items_sent < 1400)
        begin
            r = $urandom_range(2, 8);
            c = $urandom_range(2, 8);
            set_frame(r, c);
            idle_on = ($urandom_range(0, 3) != 0);
            send_frame(r, c);
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_counts();
        test_extremes();
        test_clamped_counts();
        test_midframe_change();
        test_backpressure();
        test_random_frames();
        stop_sending();
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
